[design/aep_pkg.sv]
// shared types and constants for the address event packetizer
// used by aep_front, aep_queue, aep_back and address_event_packetizer_core
`default_nettype none

package aep_pkg;

	localparam int unsigned OPCODE_W    = 2;
	localparam int unsigned RECORD_W    = 32;
	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned BEAT_W      = 2;
	localparam int unsigned IN_DATA_W   = 32;
	localparam int unsigned IN_USER_W   = 2;
	localparam int unsigned OUT_USER_W  = 2;

	localparam logic [BYTE_W-1:0] WRAP_MARK = 8'hFF;
	localparam logic [BEAT_W-1:0] LAST_BEAT = 2'd3;

	typedef enum logic [OPCODE_W-1:0] {
		OP_EVENT = 2'd0,
		OP_WRAP  = 2'd1,
		OP_IDLE  = 2'd2,
		OP_CLEAR = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_IDLE   = 2'd1,
		CMD_CLEAR  = 2'd2
	} cmd_kind_t;

	// record bytes in send order, first byte in the lowest bits
	typedef struct packed {
		cmd_kind_t           kind;
		logic [RECORD_W-1:0] record;
	} cmd_t;

endpackage

`default_nettype wire

[design/address_event_packetizer_core.sv]
// Address event packetizer: turns event, timestamp wrap, idle tick and clear
// items into the byte stream of a packet FIFO, with packet commits every
// PACKET_BYTES bytes and on idle ticks with a partly filled packet. An event or
// wrap item leaves as four bytes, one per cycle unless m_tready stalls, through
// the single output byte register; idle ticks and clears go through the queue
// to the byte sequencer, and items dropped while acquisition is disabled are
// never queued. A queue of QUEUE_DEPTH commands lets the input side run ahead
// of the byte sequencer, so input transfers continue while bytes drain. No
// clearing pass is needed after reset. Write cfg_wr_en only while idle.
// depends on aep_pkg, aep_front, aep_queue, aep_back
`default_nettype none

module address_event_packetizer_core #(
	parameter int unsigned PACKET_BYTES = 64,
	parameter int unsigned QUEUE_DEPTH  = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_wr_data,   // acquisition_enabled
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [aep_pkg::IN_DATA_W-1:0] s_tdata,       // event_address, event_timestamp
	input  wire logic [aep_pkg::IN_USER_W-1:0] s_tuser,       // opcode
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [aep_pkg::BYTE_W-1:0]         m_tdata,       // out_byte
	output logic [aep_pkg::OUT_USER_W-1:0]     m_tuser,       // byte_valid, packet_commit
	output logic                               m_tlast
);
	import aep_pkg::*;

	logic q_full;
	logic q_push;
	cmd_t q_cmd;
	logic q_pop;
	cmd_t q_head;
	logic q_empty;

	aep_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_cmd       (q_cmd)
	);

	aep_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty)
	);

	aep_back #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.empty    (q_empty),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

[design/aep_front.sv]
// front end: input transfer, acquisition enable register, item classification
// depends on aep_pkg
`default_nettype none

module aep_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic                          cfg_wr_data,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	input  wire logic [aep_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic [aep_pkg::IN_USER_W-1:0] s_tuser,
	input  wire logic                          q_full,
	output logic                               q_push,
	output aep_pkg::cmd_t                      q_cmd
);
	import aep_pkg::*;

	logic    acq_en_q;
	opcode_t opcode;
	logic    accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acq_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			acq_en_q <= cfg_wr_data;
		end
	end

	assign opcode   = opcode_t'(s_tuser);
	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;
	assign q_push   = accept && (opcode == OP_CLEAR || acq_en_q);

	always_comb begin
		q_cmd.record = {s_tdata[23:16], s_tdata[31:24], s_tdata[15:8], s_tdata[7:0]};
		unique case (opcode)
			OP_EVENT: begin
				q_cmd.kind = CMD_RECORD;
			end
			OP_WRAP: begin
				q_cmd.kind   = CMD_RECORD;
				q_cmd.record = {{(2*BYTE_W){1'b0}}, WRAP_MARK, WRAP_MARK};
			end
			OP_IDLE: begin
				q_cmd.kind = CMD_IDLE;
			end
			OP_CLEAR: begin
				q_cmd.kind = CMD_CLEAR;
			end
			default: begin
				q_cmd.kind = CMD_CLEAR;
			end
		endcase
	end

endmodule

`default_nettype wire

[design/aep_queue.sv]
// command queue between front and back end
// depends on aep_pkg
`default_nettype none

module aep_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire aep_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output aep_pkg::cmd_t      head,
	output logic               empty
);
	import aep_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	cmd_t            entry_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (count_q == FullCnt);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[design/aep_back.sv]
// back end: byte sequencing, packet byte count, output register
// depends on aep_pkg
`default_nettype none

module aep_back #(
	parameter int unsigned PACKET_BYTES = 64
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire aep_pkg::cmd_t                  head,
	input  wire logic                           empty,
	output logic                                pop,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [aep_pkg::BYTE_W-1:0]          m_tdata,
	output logic [aep_pkg::OUT_USER_W-1:0]      m_tuser,
	output logic                                m_tlast
);
	import aep_pkg::*;

	localparam int unsigned CountW = $clog2(PACKET_BYTES);
	localparam logic [CountW-1:0] LastCount = CountW'(PACKET_BYTES - 1);

	logic [CountW-1:0] count_q;
	logic [BEAT_W-1:0] beat_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_bvalid_q;
	logic              out_commit_q;
	logic              out_last_q;

	logic              out_free;
	logic              load;
	logic              load_byte;
	logic              wrap_count;
	logic              zero_count;
	logic [BYTE_W-1:0] sel_byte;

	assign out_free   = !out_valid_q || m_tready;
	assign wrap_count = (count_q == LastCount);
	assign sel_byte   = head.record[beat_q*BYTE_W +: BYTE_W];

	always_comb begin
		pop        = 1'b0;
		load       = 1'b0;
		load_byte  = 1'b0;
		zero_count = 1'b0;
		if (!empty) begin
			unique case (head.kind)
				CMD_RECORD: begin
					if (out_free) begin
						load      = 1'b1;
						load_byte = 1'b1;
						pop       = (beat_q == LAST_BEAT);
					end
				end
				CMD_IDLE: begin
					if (count_q == '0) begin
						pop = 1'b1;
					end else if (out_free) begin
						load       = 1'b1;
						pop        = 1'b1;
						zero_count = 1'b1;
					end
				end
				CMD_CLEAR: begin
					pop        = 1'b1;
					zero_count = 1'b1;
				end
				default: begin
					pop = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			beat_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (load_byte) begin
				beat_q  <= beat_q + 1'b1;
				count_q <= wrap_count ? '0 : count_q + 1'b1;
			end else if (zero_count) begin
				count_q <= '0;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q   <= load_byte ? sel_byte : '0;
			out_bvalid_q <= load_byte;
			out_commit_q <= load_byte ? wrap_count : 1'b1;
			out_last_q   <= load_byte ? (beat_q == LAST_BEAT) : 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_byte_q;
	assign m_tuser  = {out_commit_q, out_bvalid_q};
	assign m_tlast  = out_last_q;

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for address_event_packetizer_core: directed and random items,
// with every expected fifo action predicted at acceptance and compared field by field
// depends on aep_pkg and the rtl of address_event_packetizer_core
`default_nettype none

module testbench;
	import aep_pkg::*;

	localparam int unsigned PACKET_BYTES   = 64;
	localparam int unsigned SETTLE_CYCLES  = 32;
	localparam int unsigned WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic              byte_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              packet_commit;
		logic              last;
	} fifo_action_t;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 cfg_wr_en   = 1'b0;
	logic                 cfg_wr_data = 1'b0;
	logic                 s_tvalid    = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata     = '0;
	logic [IN_USER_W-1:0] s_tuser     = '0;
	logic                 m_tvalid;
	logic                 m_tready    = 1'b0;
	logic [BYTE_W-1:0]    m_tdata;
	logic [OUT_USER_W-1:0] m_tuser;
	logic                 m_tlast;

	fifo_action_t expected_actions[$];
	fifo_action_t next_action;
	int unsigned  pkt_fill       = 0;
	logic         acq_on         = 1'b0;
	int unsigned  mismatch_count = 0;
	int unsigned  quiet_cycles   = 0;
	int unsigned  ready_hold     = 0;
	logic         tx_gaps_on     = 1'b1;
	logic         rx_stalls_on   = 1'b1;

	address_event_packetizer_core #(
		.PACKET_BYTES(PACKET_BYTES)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic void push_fifo_byte(logic [BYTE_W-1:0] b, logic is_last);
		fifo_action_t a;
		a.byte_valid    = 1'b1;
		a.out_byte      = b;
		a.packet_commit = 1'b0;
		a.last          = is_last;
		pkt_fill++;
		if (pkt_fill >= PACKET_BYTES) begin
			a.packet_commit = 1'b1;
			pkt_fill        = 0;
		end
		expected_actions.push_back(a);
	endfunction

	function automatic void push_record(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
			logic [7:0] b3);
		push_fifo_byte(b0, 1'b0);
		push_fifo_byte(b1, 1'b0);
		push_fifo_byte(b2, 1'b0);
		push_fifo_byte(b3, 1'b1);
	endfunction

	function automatic void predict_item(opcode_t op, logic [15:0] addr, logic [15:0] ts);
		fifo_action_t a;
		if (op == OP_CLEAR) begin
			pkt_fill = 0;
		end else if (acq_on) begin
			case (op)
				OP_EVENT: begin
					push_record(addr[7:0], addr[15:8], ts[15:8], ts[7:0]);
				end
				OP_WRAP: begin
					push_record(WRAP_MARK, WRAP_MARK, 8'h00, 8'h00);
				end
				default: begin
					if (pkt_fill != 0) begin
						pkt_fill        = 0;
						a.byte_valid    = 1'b0;
						a.out_byte      = '0;
						a.packet_commit = 1'b1;
						a.last          = 1'b1;
						expected_actions.push_back(a);
					end
				end
			endcase
		end
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("mismatch %0s: got %0h expected %0h at %0t", what, got, want, $realtime);
		mismatch_count++;
	endtask

	// called at a rising edge; returns at the edge of the transfer
	task automatic send_item(opcode_t op, logic [15:0] addr, logic [15:0] ts);
		int unsigned gap;
		gap = tx_gaps_on ? pick_gap() : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {ts, addr};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predict_item(op, addr, ts);
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_actions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_acquisition(logic en);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= en;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		acq_on = en;
	endtask

	task automatic send_random_item();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 72)
			send_item(OP_EVENT, 16'($urandom), 16'($urandom));
		else if (r < 86)
			send_item(OP_WRAP, 16'($urandom), 16'($urandom));
		else if (r < 95)
			send_item(OP_IDLE, 16'($urandom), 16'($urandom));
		else
			send_item(OP_CLEAR, 16'($urandom), 16'($urandom));
	endtask

	task automatic test_acquisition_disabled();
		send_item(OP_EVENT, 16'h1234, 16'h5678);
		send_item(OP_WRAP, 16'hFFFF, 16'hFFFF);
		send_item(OP_IDLE, 16'h0000, 16'h0000);
		send_item(OP_CLEAR, 16'hFFFF, 16'h0000);
	endtask

	task automatic test_event_bytes();
		send_item(OP_EVENT, 16'h0000, 16'h0000);
		send_item(OP_EVENT, 16'hFFFF, 16'hFFFF);
		send_item(OP_EVENT, 16'hA55A, 16'h5AA5);
	endtask

	task automatic test_wrap_record();
		send_item(OP_WRAP, 16'h0F0F, 16'hF0F0);
	endtask

	task automatic test_idle_commit();
		// partial packet commits, then an empty one gives nothing
		send_item(OP_IDLE, 16'h0000, 16'h0000);
		send_item(OP_IDLE, 16'hFFFF, 16'hFFFF);
	endtask

	task automatic test_packet_fill();
		int i;
		for (i = 0; i < PACKET_BYTES / 4; i++) begin
			if (i % 3 == 2)
				send_item(OP_WRAP, 16'($urandom), 16'($urandom));
			else
				send_item(OP_EVENT, 16'($urandom), 16'($urandom));
		end
		send_item(OP_IDLE, 16'h0000, 16'h0000);
	endtask

	task automatic test_clear_while_disabled();
		send_item(OP_EVENT, 16'hC3C3, 16'h3C3C);
		set_acquisition(1'b0);
		send_item(OP_IDLE, 16'h0000, 16'h0000);
		send_item(OP_CLEAR, 16'h0000, 16'h0000);
		set_acquisition(1'b1);
		send_item(OP_IDLE, 16'h0000, 16'h0000);
	endtask

	task automatic test_random_traffic();
		int i;
		for (i = 0; i < 50; i++)
			send_random_item();
		// full rate on both sides
		tx_gaps_on   = 1'b0;
		rx_stalls_on = 1'b0;
		for (i = 0; i < 60; i++)
			send_random_item();
		tx_gaps_on   = 1'b1;
		rx_stalls_on = 1'b1;
		set_acquisition(1'b0);
		for (i = 0; i < 20; i++)
			send_random_item();
		set_acquisition(1'b1);
		for (i = 0; i < 90; i++)
			send_random_item();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_hold <= 0;
		end else if (!rx_stalls_on) begin
			m_tready <= 1'b1;
		end else if (ready_hold != 0) begin
			ready_hold <= ready_hold - 1;
		end else begin
			m_tready   <= ($urandom_range(0, 2) != 0);
			ready_hold <= pick_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_actions.size() == 0) begin
				report_mismatch("unexpected transfer, byte", m_tdata, 0);
			end else begin
				next_action = expected_actions.pop_front();
				if (m_tuser[0] !== next_action.byte_valid)
					report_mismatch("byte_valid", m_tuser[0], next_action.byte_valid);
				if (m_tdata !== next_action.out_byte)
					report_mismatch("out_byte", m_tdata, next_action.out_byte);
				if (m_tuser[1] !== next_action.packet_commit)
					report_mismatch("packet_commit", m_tuser[1], next_action.packet_commit);
				if (m_tlast !== next_action.last)
					report_mismatch("last", m_tlast, next_action.last);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_acquisition_disabled();
		set_acquisition(1'b1);
		test_event_bytes();
		test_wrap_record();
		test_idle_commit();
		test_packet_fill();
		test_clear_while_disabled();
		test_random_traffic();
		wait_idle();
		if (mismatch_count == 0 && expected_actions.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[filelist.f]
design/aep_pkg.sv
design/aep_front.sv
design/aep_queue.sv
design/aep_back.sv
design/address_event_packetizer_core.sv
tb/testbench.sv
